FILE: rtl/ssd_pkg.sv
package ssd_pkg;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_SET_NUM   = 3'd1,
    REQ_SET_DIGIT = 3'd2,
    REQ_SET_SEG   = 3'd3,
    REQ_CLEAR     = 3'd4,
    REQ_SHIFT_L   = 3'd5,
    REQ_SHIFT_R   = 3'd6,
    REQ_UNUSED    = 3'd7
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EMIT = 5'b00010,
    ST_DIV0 = 5'b00100,
    ST_CONV = 5'b01000,
    ST_SIGN = 5'b10000
  } state_t;

  localparam logic [7:0]  SEG_BLANK  = 8'h00;
  localparam logic [7:0]  SEG_MIDDLE = 8'h40;
  localparam logic [7:0]  SEG_POINT  = 8'h80;
  localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;

  localparam logic [7:0] DIGIT_PATTERN [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  function automatic logic [7:0] pattern_of(logic [31:0] v);
    logic [7:0] p;
    p = SEG_BLANK;
    if (v <= 32'd9) begin
      p = DIGIT_PATTERN[v[3:0]];
    end
    return p;
  endfunction

endpackage

FILE: rtl/ssd_if.sv
interface ssd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [2:0]  position;
  logic signed [31:0] value;
  logic        point_on;
  logic [2:0]  segment;
  logic        segment_on;

  modport source (output valid, req_type, position, value, point_on, segment, segment_on,
                  input ready);
  modport sink (input valid, req_type, position, value, point_on, segment, segment_on,
                output ready);
endinterface

interface ssd_disp_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [2:0] digit_select;

  modport source (output valid, segments, digit_select, input ready);
  modport sink (input valid, segments, digit_select, output ready);
endinterface

interface ssd_cfg_if;
  logic valid;
  logic ready;
  logic reverse_order;

  modport source (output valid, reverse_order, input ready);
  modport sink (input valid, reverse_order, output ready);
endinterface

FILE: rtl/seven_segment_display_controller_unit.sv
// Channel  Role    Payload
// req      sink    req_type, position, value, point_on, segment, segment_on
// disp     source  segments, digit_select
// cfg      sink    reverse_order
//
// Buffer writes (digit, segment, clear, shift) finish in the accept cycle.
// A tick latches the scanned byte, then loads the output register once disp can take it.
// Set number runs one divide-by-ten step a cycle through a shared reciprocal
// multiplier, then a step for the minus bar on negative values.
// Reset clears the buffer, the scan index, reverse_order and the output valid.
// req.ready is low while a request is in work; a stalled tick holds in its state.
module seven_segment_display_controller_unit #(
  parameter int DIGITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  ssd_req_if.sink    req,
  ssd_disp_if.source disp,
  ssd_cfg_if.sink    cfg
);

  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CNT_W = $clog2(DIGITS + 1);

  ssd_pkg::state_t state;
  ssd_pkg::req_t   req_code;

  logic [7:0]       buffer   [DIGITS];
  logic [7:0]       buf_next [DIGITS];
  logic [IDX_W-1:0] scan_index;
  logic             reverse_order;

  logic [31:0]      m;
  logic [31:0]      m_prev;
  logic             neg;
  logic [CNT_W-1:0] k;
  logic [63:0]      prod;
  logic [31:0]      quot;
  logic [31:0]      rem_full;
  logic [IDX_W-1:0] k_phys;

  logic             accept;
  logic             pos_ok;
  logic [IDX_W-1:0] pos_phys;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_byte;
  logic [7:0]       seg_mask;

  logic [7:0]       pend_seg;
  logic [IDX_W-1:0] pend_sel;
  logic             out_valid;
  logic [7:0]       out_seg;
  logic [2:0]       out_sel;
  logic             emit_load;

  assign req_code = ssd_pkg::req_t'(req.req_type);
  assign req.ready = (state == ssd_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign disp.valid        = out_valid;
  assign disp.segments     = out_seg;
  assign disp.digit_select = out_sel;

  assign emit_load = (state == ssd_pkg::ST_EMIT) && (!out_valid || disp.ready);

  assign pos_ok   = ({1'b0, req.position} < 4'(DIGITS));
  assign pos_phys = reverse_order ? (IDX_W'(DIGITS - 1) - req.position[IDX_W-1:0])
                                  : req.position[IDX_W-1:0];
  assign rd_addr  = (req_code == ssd_pkg::REQ_TICK) ? scan_index : pos_phys;
  assign rd_byte  = ({1'b0, rd_addr} < (IDX_W + 1)'(DIGITS)) ? buffer[rd_addr]
                                                             : ssd_pkg::SEG_BLANK;
  assign seg_mask = 8'(1) << req.segment;

  assign prod     = m * ssd_pkg::RECIP_10;
  assign quot     = {3'b000, prod[63:35]};
  assign rem_full = m_prev - {m[28:0], 3'b000} - {m[30:0], 1'b0};
  assign k_phys   = reverse_order ? k[IDX_W-1:0] : (IDX_W'(DIGITS - 1) - k[IDX_W-1:0]);

  always_comb begin
    for (int j = 0; j < DIGITS; j++) begin
      buf_next[j] = buffer[j];
    end
    unique case (state)
      ssd_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_code) inside
            ssd_pkg::REQ_SET_NUM: begin
              for (int j = 0; j < DIGITS; j++) begin
                buf_next[j] = ssd_pkg::SEG_BLANK;
              end
            end
            ssd_pkg::REQ_SET_DIGIT: begin
              if (pos_ok) begin
                buf_next[pos_phys] = ssd_pkg::pattern_of(req.value)
                                     | (req.point_on ? ssd_pkg::SEG_POINT : ssd_pkg::SEG_BLANK);
              end
            end
            ssd_pkg::REQ_SET_SEG: begin
              if (pos_ok) begin
                buf_next[pos_phys] = req.segment_on ? (rd_byte | seg_mask)
                                                    : (rd_byte & ~seg_mask);
              end
            end
            ssd_pkg::REQ_CLEAR: begin
              if (pos_ok) begin
                buf_next[pos_phys] = ssd_pkg::SEG_BLANK;
              end
            end
            ssd_pkg::REQ_SHIFT_L, ssd_pkg::REQ_SHIFT_R: begin
              if ((req_code == ssd_pkg::REQ_SHIFT_L) != reverse_order) begin
                for (int j = DIGITS - 1; j > 0; j--) begin
                  buf_next[j] = buffer[j-1];
                end
                buf_next[0] = ssd_pkg::pattern_of(req.value);
              end else begin
                for (int j = 0; j < DIGITS - 1; j++) begin
                  buf_next[j] = buffer[j+1];
                end
                buf_next[DIGITS-1] = ssd_pkg::pattern_of(req.value);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ssd_pkg::ST_CONV: begin
        if ((m != 32'd0) && (k == CNT_W'(DIGITS - 1))) begin
          for (int j = 0; j < DIGITS; j++) begin
            buf_next[j] = ssd_pkg::SEG_MIDDLE;
          end
        end else begin
          buf_next[k_phys] = ssd_pkg::pattern_of({28'd0, rem_full[3:0]});
        end
      end
      ssd_pkg::ST_SIGN: begin
        if (k == CNT_W'(DIGITS)) begin
          for (int j = 0; j < DIGITS; j++) begin
            buf_next[j] = ssd_pkg::SEG_MIDDLE;
          end
        end else begin
          buf_next[k_phys] = ssd_pkg::SEG_MIDDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ssd_pkg::ST_IDLE;
      scan_index    <= '0;
      reverse_order <= 1'b0;
      out_valid     <= 1'b0;
      for (int j = 0; j < DIGITS; j++) begin
        buffer[j] <= ssd_pkg::SEG_BLANK;
      end
    end else begin
      for (int j = 0; j < DIGITS; j++) begin
        buffer[j] <= buf_next[j];
      end
      if (cfg.valid && cfg.ready) begin
        reverse_order <= cfg.reverse_order;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && disp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ssd_pkg::ST_IDLE: begin
          if (accept) begin
            if (req_code == ssd_pkg::REQ_TICK) begin
              pend_seg   <= rd_byte;
              pend_sel   <= scan_index;
              scan_index <= (scan_index == IDX_W'(DIGITS - 1)) ? '0 : scan_index + 1'b1;
              state      <= ssd_pkg::ST_EMIT;
            end else if (req_code == ssd_pkg::REQ_SET_NUM) begin
              neg   <= req.value[31];
              m     <= req.value[31] ? (32'd0 - req.value) : req.value;
              state <= ssd_pkg::ST_DIV0;
            end
          end
        end
        ssd_pkg::ST_EMIT: begin
          if (emit_load) begin
            out_seg <= pend_seg;
            out_sel <= 3'(pend_sel);
            state   <= ssd_pkg::ST_IDLE;
          end
        end
        ssd_pkg::ST_DIV0: begin
          m_prev <= m;
          m      <= quot;
          k      <= '0;
          state  <= ssd_pkg::ST_CONV;
        end
        ssd_pkg::ST_CONV: begin
          m_prev <= m;
          m      <= quot;
          k      <= k + 1'b1;
          if (m == 32'd0) begin
            state <= neg ? ssd_pkg::ST_SIGN : ssd_pkg::ST_IDLE;
          end else if (k == CNT_W'(DIGITS - 1)) begin
            state <= ssd_pkg::ST_IDLE;
          end
        end
        ssd_pkg::ST_SIGN: begin
          state <= ssd_pkg::ST_IDLE;
        end
        default: begin
          state <= ssd_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/ssd_scan_checker.sv
`timescale 1ns / 100ps

module ssd_scan_checker
  import ssd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ssd_req_if         req,
  ssd_disp_if        disp,
  ssd_cfg_if         cfg,
  output int         mismatches,
  output int         outstanding
);

  localparam int DIGITS = 8;

  localparam logic [7:0] GLYPH [10] = '{
    8'b00111111, 8'b00000110, 8'b01011011, 8'b01001111, 8'b01100110,
    8'b01101101, 8'b01111101, 8'b00000111, 8'b01111111, 8'b01101111
  };

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] digit_select;
  } scan_beat_t;

  logic [7:0] shown [DIGITS];
  logic [2:0] scan_ptr;
  logic       mirrored;
  scan_beat_t expected_scans [$];
  scan_beat_t want;

  function automatic logic [2:0] phys_of(logic [2:0] p);
    return mirrored ? 3'(DIGITS - 1 - p) : p;
  endfunction

  function automatic logic [7:0] glyph(logic [31:0] v);
    return (v <= 32'd9) ? GLYPH[v] : SEG_BLANK;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, exp_val, $realtime);
    mismatches++;
  endtask

  task automatic apply_request(input req_t kind, input logic [2:0] pos,
                               input logic [31:0] val, input logic pt,
                               input logic [2:0] seg, input logic son);
    logic [7:0]  lv [DIGITS];
    logic [31:0] mag;
    logic [31:0] m;
    logic        neg;
    int          n;
    for (int p = 0; p < DIGITS; p++) lv[p] = shown[phys_of(3'(p))];
    case (kind)
      REQ_TICK: begin
        expected_scans.push_back('{shown[scan_ptr], scan_ptr});
        scan_ptr = scan_ptr + 3'd1;
      end
      REQ_SET_NUM: begin
        neg = val[31];
        mag = neg ? (32'd0 - val) : val;
        m = mag;
        n = 0;
        do begin
          n++;
          m = m / 10;
        end while (m != 0);
        if (n + int'(neg) > DIGITS) begin
          for (int p = 0; p < DIGITS; p++) lv[p] = SEG_MIDDLE;
        end else begin
          for (int p = 0; p < DIGITS; p++) lv[p] = SEG_BLANK;
          m = mag;
          for (int i = 0; i < n; i++) begin
            lv[DIGITS - 1 - i] = glyph(m % 10);
            m = m / 10;
          end
          if (neg) lv[DIGITS - 1 - n] = SEG_MIDDLE;
        end
      end
      REQ_SET_DIGIT: lv[pos] = glyph(val) | (pt ? SEG_POINT : SEG_BLANK);
      REQ_SET_SEG:   lv[pos][seg] = son;
      REQ_CLEAR:     lv[pos] = SEG_BLANK;
      REQ_SHIFT_L: begin
        for (int p = DIGITS - 1; p > 0; p--) lv[p] = lv[p - 1];
        lv[0] = glyph(val);
      end
      REQ_SHIFT_R: begin
        for (int p = 0; p < DIGITS - 1; p++) lv[p] = lv[p + 1];
        lv[DIGITS - 1] = glyph(val);
      end
      default: ;
    endcase
    for (int p = 0; p < DIGITS; p++) shown[phys_of(3'(p))] = lv[p];
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < DIGITS; p++) shown[p] = SEG_BLANK;
      scan_ptr = 3'd0;
      mirrored = 1'b0;
      mismatches = 0;
      expected_scans.delete();
    end else begin
      if (cfg.valid && cfg.ready) mirrored = cfg.reverse_order;
      if (req.valid && req.ready) begin
        apply_request(req_t'(req.req_type), req.position, req.value, req.point_on,
                      req.segment, req.segment_on);
      end
      if (disp.valid && disp.ready) begin
        if (expected_scans.size() == 0) begin
          report_mismatch("display beat with none pending", {21'd0, disp.digit_select,
                          disp.segments}, 32'd0);
        end else begin
          want = expected_scans.pop_front();
          if (disp.segments !== want.segments)
            report_mismatch("segments", disp.segments, want.segments);
          if (disp.digit_select !== want.digit_select)
            report_mismatch("digit_select", disp.digit_select, want.digit_select);
        end
      end
    end
    outstanding = expected_scans.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ssd_pkg::*;

  localparam int RUN_LIMIT = 400000;

  logic clk;
  logic rst;
  bit   quiet;
  int   check_fails;
  int   pending_scans;
  int   cycle_count = 0;
  int   hold_left;

  ssd_req_if  req_ch ();
  ssd_disp_if disp_ch ();
  ssd_cfg_if  cfg_ch ();

  seven_segment_display_controller_unit #(.DIGITS(8)) dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .disp (disp_ch),
    .cfg  (cfg_ch)
  );

  ssd_scan_checker scan_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .disp        (disp_ch),
    .cfg         (cfg_ch),
    .mismatches  (check_fails),
    .outstanding (pending_scans)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("seven_segment_display_controller_unit verification failed");
      $finish;
    end
  end

  // hold ready low a random number of cycles after each beat
  always @(posedge clk) begin
    if (rst) begin
      disp_ch.ready <= 1'b0;
      hold_left = 0;
    end else if (disp_ch.ready && disp_ch.valid) begin
      hold_left = quiet ? 0 : $urandom_range(0, 7);
      disp_ch.ready <= (hold_left == 0);
    end else if (!disp_ch.ready) begin
      if (hold_left > 0) hold_left--;
      if (hold_left == 0) disp_ch.ready <= 1'b1;
    end
  end

  task automatic send_req(input req_t kind, input logic [2:0] pos, input logic [31:0] val,
                          input logic pt, input logic [2:0] seg, input logic son);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.position   <= pos;
    req_ch.value      <= val;
    req_ch.point_on   <= pt;
    req_ch.segment    <= seg;
    req_ch.segment_on <= son;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // drop valid and wait out every pending scan beat plus conversion time
  task automatic drain_requests;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_scans != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reverse(input logic rev);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.reverse_order <= rev;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_number();
    logic [31:0] mag;
    logic        neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: mag = $urandom_range(0, 99999999);
      2: begin
        case ($urandom_range(0, 7))
          0: return 32'd99999999;
          1: return 32'd100000000;
          2: return 32'(-9999999);
          3: return 32'(-10000000);
          4: return 32'h8000_0000;
          5: return 32'h7FFF_FFFF;
          6: return 32'hFFFF_FFFF;
          default: return 32'd0;
        endcase
      end
      default: mag = $urandom_range(0, 999);
    endcase
    return neg ? (32'd0 - mag) : mag;
  endfunction

  task automatic random_request;
    int          r;
    req_t        kind;
    logic [31:0] val;
    r = $urandom_range(0, 99);
    if (r < 24)      kind = REQ_TICK;
    else if (r < 48) kind = REQ_SET_NUM;
    else if (r < 62) kind = REQ_SET_DIGIT;
    else if (r < 74) kind = REQ_SET_SEG;
    else if (r < 82) kind = REQ_CLEAR;
    else if (r < 90) kind = REQ_SHIFT_L;
    else if (r < 98) kind = REQ_SHIFT_R;
    else             kind = REQ_UNUSED;
    if (kind == REQ_SET_NUM) val = pick_number();
    else if ($urandom_range(0, 4) == 0) val = $urandom;
    else val = $urandom_range(0, 9);
    send_req(kind, 3'($urandom_range(0, 7)), val, 1'($urandom_range(0, 1)),
             3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst                  <= 1'b1;
    quiet                = 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= REQ_TICK;
    req_ch.position      <= 3'd0;
    req_ch.value         <= 32'd0;
    req_ch.point_on      <= 1'b0;
    req_ch.segment       <= 3'd0;
    req_ch.segment_on    <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.reverse_order <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reverse(1'b0);
    send_req(REQ_SET_NUM, 3'd0, 32'h7FFF_FFFF, 1'b0, 3'd0, 1'b0);
    send_req(REQ_TICK, 3'd0, 32'd0, 1'b0, 3'd0, 1'b0);
    send_req(REQ_SET_NUM, 3'd0, 32'h8000_0000, 1'b1, 3'd7, 1'b1);
    send_req(REQ_SET_NUM, 3'd0, 32'd12345678, 1'b0, 3'd0, 1'b0);
    send_req(REQ_SET_NUM, 3'd0, 32'(-1234567), 1'b0, 3'd0, 1'b0);
    send_req(REQ_SET_NUM, 3'd0, 32'(-12345678), 1'b0, 3'd0, 1'b0);
    send_req(REQ_SET_NUM, 3'd0, 32'd0, 1'b0, 3'd0, 1'b0);
    send_req(REQ_SET_DIGIT, 3'd7, 32'd9, 1'b1, 3'd0, 1'b0);
    send_req(REQ_SET_DIGIT, 3'd0, 32'd10, 1'b1, 3'd0, 1'b0);
    send_req(REQ_SET_DIGIT, 3'd3, 32'hFFFF_FFFF, 1'b0, 3'd0, 1'b0);
    send_req(REQ_SET_SEG, 3'd0, 32'd0, 1'b0, 3'd7, 1'b1);
    send_req(REQ_SET_SEG, 3'd7, 32'd0, 1'b0, 3'd0, 1'b0);
    send_req(REQ_CLEAR, 3'd5, 32'd0, 1'b0, 3'd0, 1'b0);
    send_req(REQ_SHIFT_L, 3'd0, 32'd5, 1'b0, 3'd0, 1'b0);
    send_req(REQ_SHIFT_R, 3'd0, 32'd100, 1'b0, 3'd0, 1'b0);
    send_req(REQ_UNUSED, 3'd7, 32'hFFFF_FFFF, 1'b1, 3'd7, 1'b1);
    repeat (8) send_req(REQ_TICK, 3'd0, 32'd0, 1'b0, 3'd0, 1'b0);
    drain_requests();

    for (int phase = 0; phase < 4; phase++) begin
      write_reverse(phase % 2 == 0);
      for (int i = 0; i < 300; i++) begin
        quiet = (i >= 120 && i < 170);
        if (i == 220) drain_requests();
        random_request();
      end
      quiet = 1'b0;
      drain_requests();
    end

    if (check_fails == 0 && pending_scans == 0) begin
      $display("seven_segment_display_controller_unit verification clean");
    end else begin
      $display("seven_segment_display_controller_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ssd_pkg.sv
rtl/ssd_if.sv
rtl/seven_segment_display_controller_unit.sv
tb/ssd_scan_checker.sv
tb/testbench.sv
